FILE: hw/rtl/bblq_pkg.sv
// ----------------------------------------------------------------------------
// bblq_pkg
// types and constants shared by the link queue controller, datapath and top
// ----------------------------------------------------------------------------
package bblq_pkg;

  // fixed field widths of the transaction payloads
  localparam int TAG_W    = 16;
  localparam int BYTES_W  = 20;
  localparam int TOTAL_W  = 24;
  localparam int CHUNKS_W = 5;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [TOTAL_W-1:0] CAPACITY_RESET  = 24'd65536;
  localparam logic [TOTAL_W-1:0] THRESHOLD_RESET = 24'd32768;

  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_DRAIN    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DISP_STARTED        = 3'd0,
    DISP_QUEUED         = 3'd1,
    DISP_DROPPED_FULL   = 3'd2,
    DISP_COMPLETED      = 3'd3,
    DISP_NOTHING_ACTIVE = 3'd4,
    DISP_DRAINED        = 3'd5,
    DISP_DRAIN_EMPTY    = 3'd6,
    DISP_REJECTED_ZERO  = 3'd7
  } disp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic               mark;
  } chunk_t;

  localparam int CHUNK_W = $bits(chunk_t);

  typedef struct packed {
    op_t                operation;
    logic [TAG_W-1:0]   in_tag;
    logic [BYTES_W-1:0] in_bytes;
    logic               in_marked;
  } in_item_t;

  typedef struct packed {
    disp_t               disposition;
    logic                mark_set;
    logic [TAG_W-1:0]    out_tag;
    logic [BYTES_W-1:0]  out_bytes;
    logic                out_marked;
    logic                next_valid;
    logic [TAG_W-1:0]    next_tag;
    logic [TOTAL_W-1:0]  waiting_bytes_now;
    logic [CHUNKS_W-1:0] waiting_chunks_now;
    logic [TOTAL_W-1:0]  peak_bytes;
    logic [CHUNKS_W-1:0] peak_chunks;
    logic                last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic drain_step;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic pending;
    logic drain_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/bblq_ram.sv
// ----------------------------------------------------------------------------
// bblq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bblq_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/bblq_ctrl.sv
// ----------------------------------------------------------------------------
// bblq_ctrl
// sequencer for the link queue: accept, execute, drain and output handshake
// ----------------------------------------------------------------------------
module bblq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bblq_pkg::dp_status_t status,
  output bblq_pkg::ctl_cmd_t   cmd
);
  import bblq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op == OP_NONE) begin
          state_nxt = ST_IDLE;
        end else if (status.op == OP_DRAIN && status.pending) begin
          state_nxt = ST_DRAIN;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          cmd.drain_step = 1'b1;
          cmd.emit       = 1'b1;
          if (status.drain_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && out_stall);
  end

  // a drain pass only runs while something is left to emit
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> status.pending)
    else $error("drain state with empty queue");

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("result overwritten while stalled");

endmodule

FILE: hw/rtl/bblq_datapath.sv
// ----------------------------------------------------------------------------
// bblq_datapath
// queue state, waiting store, admission and marking logic, result register
// ----------------------------------------------------------------------------
module bblq_datapath #(
  parameter int CHUNK_SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bblq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bblq_pkg::TOTAL_W-1:0]        cfg_data,
  input  bblq_pkg::in_item_t                  in_data,
  input  bblq_pkg::ctl_cmd_t                  cmd,
  output bblq_pkg::dp_status_t                status,
  output bblq_pkg::out_item_t                 out_data
);
  import bblq_pkg::*;

  localparam int IW = $clog2(CHUNK_SLOTS);
  localparam int CW = $clog2(CHUNK_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CHUNK_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CHUNK_SLOTS);

  logic [TOTAL_W-1:0] cap_r, thr_r;
  logic               mark_en_r;

  in_item_t  in_r;
  out_item_t out_r, res;

  logic [IW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt, peak_cnt_r, peak_cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt, peak_bytes_r, peak_bytes_nxt;
  logic               busy_r, busy_nxt;
  chunk_t             server_r, server_nxt;

  logic               ram_we;
  chunk_t             ram_wdata;
  logic [CHUNK_W-1:0] ram_rdata;
  chunk_t             head_chunk;

  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_new;
  logic               fits, mark_now;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAPACITY_RESET;
      mark_en_r <= 1'b0;
      thr_r     <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:  cap_r     <= cfg_data;
        CFG_MARK_EN:   mark_en_r <= cfg_data[0];
        CFG_THRESHOLD: thr_r     <= cfg_data;
        default:       ;
      endcase
    end
  end

  // transaction and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      total_r      <= '0;
      peak_bytes_r <= '0;
      peak_cnt_r   <= '0;
      busy_r       <= 1'b0;
      server_r     <= '0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      peak_bytes_r <= peak_bytes_nxt;
      peak_cnt_r   <= peak_cnt_nxt;
      busy_r       <= busy_nxt;
      server_r     <= server_nxt;
    end
  end

  // read address follows the next head so the head entry is ready each cycle
  bblq_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (CHUNK_SLOTS)
  ) u_wait_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (ram_wdata),
    .rd_addr (head_nxt),
    .rd_data (ram_rdata)
  );

  assign head_chunk = chunk_t'(ram_rdata);

  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(in_r.in_bytes);
  assign total_new = sum[TOTAL_W-1:0];
  assign fits      = (count_r < FULL_CNT) && (sum <= {1'b0, cap_r});
  assign mark_now  = mark_en_r && (total_new >= thr_r);

  assign status.op         = in_r.operation;
  assign status.pending    = busy_r || (count_r != '0);
  assign status.drain_last = busy_r ? (count_r == '0) : (count_r == CW'(1));

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    peak_bytes_nxt = peak_bytes_r;
    peak_cnt_nxt   = peak_cnt_r;
    busy_nxt       = busy_r;
    server_nxt     = server_r;
    ram_we         = 1'b0;
    ram_wdata.tag  = in_r.in_tag;
    ram_wdata.bytes = in_r.in_bytes;
    ram_wdata.mark = in_r.in_marked || mark_now;
    res            = '0;

    if (cmd.exec) begin
      case (in_r.operation)
        OP_ADMIT: begin
          if (in_r.in_bytes == '0) begin
            res.disposition = DISP_REJECTED_ZERO;
          end else if (!busy_r) begin
            server_nxt.tag   = in_r.in_tag;
            server_nxt.bytes = in_r.in_bytes;
            server_nxt.mark  = in_r.in_marked;
            busy_nxt         = 1'b1;
            res.disposition  = DISP_STARTED;
          end else if (!fits) begin
            res.disposition = DISP_DROPPED_FULL;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + IW'(1);
            count_nxt = count_r + CW'(1);
            total_nxt = total_new;
            if (total_new > peak_bytes_r) begin
              peak_bytes_nxt = total_new;
            end
            if (count_nxt > peak_cnt_r) begin
              peak_cnt_nxt = count_nxt;
            end
            res.disposition = DISP_QUEUED;
            res.mark_set    = mark_now;
          end
        end
        OP_COMPLETE: begin
          if (!busy_r) begin
            res.disposition = DISP_NOTHING_ACTIVE;
          end else begin
            res.disposition = DISP_COMPLETED;
            res.out_tag     = server_r.tag;
            res.out_bytes   = server_r.bytes;
            res.out_marked  = server_r.mark;
            if (count_r != '0) begin
              head_nxt       = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
              count_nxt      = count_r - CW'(1);
              total_nxt      = total_r - TOTAL_W'(head_chunk.bytes);
              server_nxt     = head_chunk;
              res.next_valid = 1'b1;
              res.next_tag   = head_chunk.tag;
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
        OP_DRAIN: begin
          // nothing active or waiting
          res.disposition = DISP_DRAIN_EMPTY;
          head_nxt        = '0;
          tail_nxt        = '0;
          total_nxt       = '0;
          busy_nxt        = 1'b0;
          server_nxt      = '0;
        end
        default: ;
      endcase
      res.waiting_bytes_now  = total_nxt;
      res.waiting_chunks_now = CHUNKS_W'(count_nxt);
      res.last               = 1'b1;
    end else if (cmd.drain_step) begin
      res.disposition = DISP_DRAINED;
      if (busy_r) begin
        res.out_tag    = server_r.tag;
        res.out_bytes  = server_r.bytes;
        res.out_marked = server_r.mark;
        busy_nxt       = 1'b0;
        server_nxt     = '0;
      end else begin
        res.out_tag    = head_chunk.tag;
        res.out_bytes  = head_chunk.bytes;
        res.out_marked = head_chunk.mark;
        head_nxt       = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
        count_nxt      = count_r - CW'(1);
      end
      if (status.drain_last) begin
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
        total_nxt  = '0;
        busy_nxt   = 1'b0;
        server_nxt = '0;
      end
      res.last = status.drain_last;
    end

    res.peak_bytes  = peak_bytes_nxt;
    res.peak_chunks = CHUNKS_W'(peak_cnt_nxt);
  end

  assign out_data = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("waiting count above slot count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0) && (head_r == tail_r))
    else $error("empty queue with bytes or misaligned pointers");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == FULL_CNT) |-> (head_r == tail_r))
    else $error("full queue with misaligned pointers");

endmodule

FILE: hw/rtl/byte_budget_link_queue_with_marking_core.sv
// ----------------------------------------------------------------------------
// byte_budget_link_queue_with_marking_core
// one-server link queue with byte-budget drop-tail fifo and threshold marking
// ----------------------------------------------------------------------------
// Each input transaction carries one request: admit a chunk, complete service,
// or drain. An admit, a complete and an empty drain are accepted, then executed
// into the result register; an OP_NONE request is accepted and gives no result.
// A drain of n chunks is accepted, then streams one result per cycle while the
// result side does not stall. The head entry is read through the registered
// read port of the waiting store, addressed by the next head pointer.
// A new transaction is accepted while the previous result is still
// waiting in the output register. Results come out in order, each marked with
// last on the final result of its transaction. waiting_chunks_now and
// peak_chunks carry the low five bits of the counts. Configuration writes are
// always ready and are meant to happen while the block is idle. There is no
// clearing pass after reset: store entries are only read once written.
// ----------------------------------------------------------------------------
module byte_budget_link_queue_with_marking_core #(
  parameter int CHUNK_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bblq_pkg::in_item_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output bblq_pkg::out_item_t            out_data,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bblq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bblq_pkg::TOTAL_W-1:0]   cfg_data
);
  import bblq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // register writes complete in the cycle they are offered
  assign cfg_ready = 1'b1;

  // sequencer: accepts a transaction, runs it, streams drain results
  bblq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // queue state, waiting store and result register
  bblq_datapath #(
    .CHUNK_SLOTS (CHUNK_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
